// ===== hdl/srhe_pkg.sv =====
package srhe_pkg;

   localparam int RECORD_BYTES_DEF = 16;
   localparam int PC_W = 4;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_DATA   = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [PC_W-1:0] PC_S1 = 4'd0;
   localparam logic [PC_W-1:0] PC_S9 = 4'd14;

   localparam logic [7:0] CHR_S  = 8'h53;
   localparam logic [7:0] CHR_1  = 8'h31;
   localparam logic [7:0] CHR_9  = 8'h39;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_LF = 8'h0A;

   localparam logic [7:0] S9_COUNT = 8'd3;

   typedef enum logic [2:0] {
      SRC_CONST,
      SRC_CNT,
      SRC_AHI,
      SRC_ALO,
      SRC_DATA,
      SRC_CHK
   } src_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_LOOP,
      JMP_SKIP,
      JMP_END
   } jmp_type;

   typedef struct packed {
      src_type         src;
      logic            hi_nib;
      logic [7:0]      chr;
      logic            last;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic        start;
      logic        s9;
      logic [7:0]  cnt;
      logic [15:0] addr;
      logic [7:0]  sum;
   } start_type;

   function automatic ctl_type cw(src_type src, logic hi_nib, logic [7:0] chr, logic last,
                                  jmp_type jmp, logic [PC_W-1:0] target);
      ctl_type w;
      w.src    = src;
      w.hi_nib = hi_nib;
      w.chr    = chr;
      w.last   = last;
      w.jmp    = jmp;
      w.target = target;
      return w;
   endfunction

   // record program: S1 at PC_S1, S9 at PC_S9 reusing the S1 tail
   function automatic ctl_type rom_word(logic [PC_W-1:0] pc);
      ctl_type w;
      case (pc)
         4'd0:    w = cw(SRC_CONST, 1'b0, CHR_S,  1'b0, JMP_NEXT, 4'd0);
         4'd1:    w = cw(SRC_CONST, 1'b0, CHR_1,  1'b0, JMP_NEXT, 4'd0);
         4'd2:    w = cw(SRC_CNT,   1'b1, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd3:    w = cw(SRC_CNT,   1'b0, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd4:    w = cw(SRC_AHI,   1'b1, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd5:    w = cw(SRC_AHI,   1'b0, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd6:    w = cw(SRC_ALO,   1'b1, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd7:    w = cw(SRC_ALO,   1'b0, 8'h00,  1'b0, JMP_SKIP, 4'd10);
         4'd8:    w = cw(SRC_DATA,  1'b1, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd9:    w = cw(SRC_DATA,  1'b0, 8'h00,  1'b0, JMP_LOOP, 4'd8);
         4'd10:   w = cw(SRC_CHK,   1'b1, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd11:   w = cw(SRC_CHK,   1'b0, 8'h00,  1'b0, JMP_NEXT, 4'd0);
         4'd12:   w = cw(SRC_CONST, 1'b0, CHR_CR, 1'b0, JMP_NEXT, 4'd0);
         4'd13:   w = cw(SRC_CONST, 1'b0, CHR_LF, 1'b1, JMP_END,  4'd0);
         4'd14:   w = cw(SRC_CONST, 1'b0, CHR_S,  1'b0, JMP_NEXT, 4'd0);
         4'd15:   w = cw(SRC_CONST, 1'b0, CHR_9,  1'b0, JMP_GOTO, 4'd2);
         default: w = cw(SRC_CONST, 1'b0, CHR_LF, 1'b1, JMP_END,  4'd0);
      endcase
      return w;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

// ===== hdl/srhe_sequencer.sv =====
module srhe_sequencer #(
   parameter int RECORD_BYTES = srhe_pkg::RECORD_BYTES_DEF,
   localparam int CW = $clog2(RECORD_BYTES + 1),
   localparam int IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  srhe_pkg::start_type start_i,
   input  logic [CW-1:0]       nbytes_i,
   output logic [IW-1:0]       rd_idx,
   input  logic [7:0]          rd_data,
   output logic                busy,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   localparam int PW = srhe_pkg::PC_W;

   logic                      run_ff, run_in;
   logic [srhe_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             nb_ff, nb_in;
   logic [7:0]                cnt_ff, cnt_in;
   logic [15:0]               addr_ff, addr_in;
   logic [7:0]                chk_ff, chk_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   srhe_pkg::ctl_type word;
   logic [7:0]        sel_byte;
   logic [3:0]        nib;
   logic [7:0]        chr;
   logic [CW-1:0]     idx_nx;
   logic              step;

   always_comb begin
      word = srhe_pkg::rom_word(pc_ff);
      case (word.src)
         srhe_pkg::SRC_CNT:  sel_byte = cnt_ff;
         srhe_pkg::SRC_AHI:  sel_byte = addr_ff[15:8];
         srhe_pkg::SRC_ALO:  sel_byte = addr_ff[7:0];
         srhe_pkg::SRC_DATA: sel_byte = rd_data;
         srhe_pkg::SRC_CHK:  sel_byte = chk_ff;
         default:            sel_byte = 8'h00;
      endcase
      nib = word.hi_nib ? sel_byte[7:4] : sel_byte[3:0];
      chr = (word.src == srhe_pkg::SRC_CONST) ? word.chr : srhe_pkg::hex_char(nib);
      idx_nx = idx_ff + CW'(1);
      step = run_ff && (!rsp_valid_ff || rsp_tready);

      run_in       = run_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      nb_in        = nb_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      chk_in       = chk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chr;
         rsp_last_in  = word.last;
         case (word.jmp)
            srhe_pkg::JMP_GOTO: pc_in = word.target;
            srhe_pkg::JMP_LOOP: begin
               if (idx_nx < nb_ff) begin
                  idx_in = idx_nx;
                  pc_in  = word.target;
               end else begin
                  pc_in = pc_ff + PW'(1);
               end
            end
            srhe_pkg::JMP_SKIP: begin
               if (nb_ff == '0) begin
                  pc_in = word.target;
               end else begin
                  pc_in = pc_ff + PW'(1);
               end
            end
            srhe_pkg::JMP_END:  run_in = 1'b0;
            default:            pc_in = pc_ff + PW'(1);
         endcase
      end

      if (start_i.start) begin
         run_in  = 1'b1;
         pc_in   = start_i.s9 ? srhe_pkg::PC_S9 : srhe_pkg::PC_S1;
         idx_in  = '0;
         nb_in   = nbytes_i;
         cnt_in  = start_i.cnt;
         addr_in = start_i.addr;
         chk_in  = ~(start_i.cnt + start_i.addr[15:8] + start_i.addr[7:0] + start_i.sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pc_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_ff       <= nb_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      chk_ff      <= chk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rd_idx     = idx_ff[IW-1:0];
   assign busy       = run_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/srecord_hex_encoder_top.sv =====
// channel | dir | tdata (low bit up)            | tuser | tlast
// req_    | in  | address[15:0], data_byte[7:0] | mode  | section_last
// rsp_    | out | character[7:0]                | -     | record_end
//
// One character per cycle while rsp_tready is high; an S1 record of n bytes
// is 12 + 2n chars, S9 is 12, set by the microcode sequencer stepping once per char.
// An item that starts a record holds req_tready low while the record is sequenced, so the
// next item is taken only once that record's LF is in the output register.
// Items that emit nothing leave req_tready high. req_tready is low while a record is sequenced
// and rises when its LF enters the output register.
// Synchronous active-high reset empties the buffer; buffer contents are not reset.
// rsp_tready low stalls the sequencer; the output register holds its item.
module srecord_hex_encoder_top #(
   parameter int RECORD_BYTES = srhe_pkg::RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], data_byte[23:16]
   input  logic [1:0]  req_tuser,   // mode
   input  logic        req_tlast,   // section_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character
   output logic        rsp_tlast    // record_end
);

   localparam int CW = $clog2(RECORD_BYTES + 1);
   localparam int IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   addr_ff, addr_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    buf_ff [RECORD_BYTES];

   srhe_pkg::start_type start;
   logic [CW-1:0]       nbytes;
   logic [IW-1:0]       rd_idx;
   logic                busy;
   logic                accept;
   logic [15:0]         req_addr;
   logic [7:0]          req_byte;
   logic [CW-1:0]       count_nx;
   logic [7:0]          sum_nx;
   logic                buf_we;

   assign req_addr   = req_tdata[15:0];
   assign req_byte   = req_tdata[23:16];
   assign req_tready = !busy;
   assign accept     = req_tvalid && !busy;
   assign count_nx   = count_ff + CW'(1);
   assign sum_nx     = sum_ff + req_byte;

   always_comb begin
      count_in   = count_ff;
      addr_in    = addr_ff;
      sum_in     = sum_ff;
      buf_we     = 1'b0;
      start      = '0;
      start.addr = addr_ff;
      start.sum  = sum_ff;
      start.cnt  = 8'(count_ff) + 8'd3;
      nbytes     = count_ff;
      if (accept) begin
         case (req_tuser)
            srhe_pkg::MODE_START: begin
               start.start = (count_ff != '0);
               count_in    = '0;
               sum_in      = 8'h00;
               addr_in     = req_addr;
            end
            srhe_pkg::MODE_DATA: begin
               buf_we = 1'b1;
               if (count_nx == CW'(RECORD_BYTES) || req_tlast) begin
                  start.start = 1'b1;
                  start.cnt   = 8'(count_nx) + 8'd3;
                  start.sum   = sum_nx;
                  nbytes      = count_nx;
                  addr_in     = addr_ff + 16'(count_nx);
                  count_in    = '0;
                  sum_in      = 8'h00;
               end else begin
                  count_in = count_nx;
                  sum_in   = sum_nx;
               end
            end
            srhe_pkg::MODE_FINISH: begin
               start.start = 1'b1;
               start.s9    = 1'b1;
               start.cnt   = srhe_pkg::S9_COUNT;
               start.addr  = req_addr;
               start.sum   = 8'h00;
               nbytes      = '0;
               count_in    = '0;
               sum_in      = 8'h00;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         addr_ff  <= 16'h0000;
         sum_ff   <= 8'h00;
      end else begin
         count_ff <= count_in;
         addr_ff  <= addr_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[count_ff[IW-1:0]] <= req_byte;
      end
   end

   srhe_sequencer #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start_i    (start),
      .nbytes_i   (nbytes),
      .rd_idx     (rd_idx),
      .rd_data    (buf_ff[rd_idx]),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/srhe_checker.sv =====
module srhe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // LF appears exactly on the record end
   a_lf_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata == srhe_pkg::CHR_LF) == rsp_tlast))
      else $error("record_end does not match LF");

   // finish always starts a record
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == srhe_pkg::MODE_FINISH |=> !req_tready)
      else $error("finish item did not start S9 record");

   // unused mode does no work
   a_mode3_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == srhe_pkg::MODE_UNUSED |=> req_tready)
      else $error("unused mode caused work");

endmodule

bind srecord_hex_encoder_top srhe_checker u_srhe_checker (.*);
